// ----- hw/rtl/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared widths, constants and types of the scanline lane-centre search.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  localparam int PIXEL_W     = 8;
  localparam int START_W     = 10;
  localparam int LIMIT_W     = 12;
  localparam int OUT_W       = 10;
  localparam int EDGE_MARGIN = 20;

  localparam logic [LIMIT_W-1:0] DARK_LIMIT_RESET = 12'd1000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEFT,
    S_RIGHT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic push;
  } win_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lsc_window.sv -----
// ----------------------------------------------------------------------------
// lsc_window
// Sliding window over the pixel stream of one scan: holds the last
// WINDOW_LEN-1 pixels and their sum, and flags an edge when the oldest held
// pixel is zero and the full window sum is within the dark limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_window import lsc_pkg::*; #(
  parameter int WINDOW_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  win_ctrl_t          ctrl,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic [LIMIT_W-1:0] dark_limit,
  output logic               hit
);

  localparam int HELD   = WINDOW_LEN - 1;
  localparam int SUM_W  = $clog2(WINDOW_LEN * 255 + 1);
  localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
  localparam int FILL_W = $clog2(WINDOW_LEN);

  logic [PIXEL_W-1:0] held [HELD];
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   total;
  logic [SUM_W-1:0]   sum_next;
  logic [FILL_W-1:0]  fill;
  logic               full;

  assign full     = (fill == FILL_W'(HELD));
  assign total    = sum + SUM_W'(pixel);
  assign sum_next = total - SUM_W'(held[HELD-1]);
  assign hit      = full && (held[HELD-1] == '0) &&
                    (CMP_W'(total) <= CMP_W'(dark_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.clear) begin
      fill <= '0;
    end else if (ctrl.push && !full) begin
      fill <= fill + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum <= '0;
      for (int k = 0; k < HELD; k++) begin
        held[k] <= '0;
      end
    end else if (ctrl.push) begin
      sum     <= sum_next;
      held[0] <= pixel;
      for (int k = 1; k < HELD; k++) begin
        held[k] <= held[k-1];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scanline_lane_center_search_core.sv -----
// ----------------------------------------------------------------------------
// scanline_lane_center_search_core
// Stores a row of pixels and searches left and right of a start column for
// dark lane edges, then reports both edges and their midpoint.
// ----------------------------------------------------------------------------
// Pixels enter one per cycle while busy is low and are written to the row
// memory. The item with row_end high raises busy for the edge search, which
// reads the row memory one column per cycle through its single read port:
// the left scan reads up to start-20+WINDOW_LEN columns, the right scan up
// to ROW_WIDTH-20-start+WINDOW_LEN columns, each stopping as soon as an edge
// is found; an emit state then forms the result, shown with done for exactly
// one cycle, which the receiver cannot hold off. A start column beyond the
// row is clamped to the last column.
`default_nettype none

module scanline_lane_center_search_core import lsc_pkg::*; #(
  parameter int ROW_WIDTH  = 640,
  parameter int WINDOW_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic [START_W-1:0] start_column,
  input  logic               row_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  output logic               done,
  output logic [OUT_W-1:0]   midpoint,
  output logic [OUT_W-1:0]   left_edge,
  output logic [OUT_W-1:0]   right_edge
);

  localparam int AW     = $clog2(ROW_WIDTH);
  localparam int CW     = AW + 2;
  localparam int EDGE_W = $clog2(ROW_WIDTH + 1);
  localparam int CNT_W  = $clog2(ROW_WIDTH + WINDOW_LEN + 1);

  localparam logic signed [CW-1:0] ROW_END_C = CW'(ROW_WIDTH);
  localparam logic signed [CW-1:0] ONE_C     = CW'(1);

  state_t                    state, state_next;
  logic [AW-1:0]             column_count, column_count_next;
  logic [LIMIT_W-1:0]        dark_limit;
  logic [PIXEL_W-1:0]        mem [ROW_WIDTH];
  logic [PIXEL_W-1:0]        rdata;
  logic                      mem_wr;
  logic [AW-1:0]             rd_addr;

  logic signed [CW-1:0]      rd_col, rd_col_next;
  logic [CNT_W-1:0]          rd_cnt, rd_cnt_next;
  logic                      p_valid, p_valid_next;
  logic                      p_inrow, p_inrow_next;
  logic signed [CW-1:0]      p_col, p_col_next;
  logic [AW-1:0]             start_col, start_col_next;
  logic [EDGE_W-1:0]         left_e, left_e_next;
  logic [EDGE_W-1:0]         right_e, right_e_next;
  logic                      done_next;
  logic [OUT_W-1:0]          midpoint_next, left_edge_next, right_edge_next;

  logic                      accept;
  logic [AW-1:0]             st_clamp;
  logic [AW-1:0]             st_sel;
  logic                      left_ok, right_ok;
  logic [CNT_W-1:0]          left_cnt, right_cnt;
  logic                      rd_inrow;
  logic                      issue;
  logic [EDGE_W-1:0]         cand;
  logic [PIXEL_W-1:0]        pix_in;
  logic [EDGE_W:0]           mid_sum;
  win_ctrl_t                 win_ctrl;
  logic                      hit;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign st_clamp  = (32'(start_column) > ROW_WIDTH - 1) ? AW'(ROW_WIDTH - 1)
                                                         : AW'(start_column);
  assign st_sel    = (state == S_IDLE) ? st_clamp : start_col;
  assign left_ok   = (int'(st_sel) >= EDGE_MARGIN);
  assign right_ok  = (int'(st_sel) <= ROW_WIDTH - EDGE_MARGIN);
  assign left_cnt  = CNT_W'(int'(st_sel) - EDGE_MARGIN + WINDOW_LEN);
  assign right_cnt = CNT_W'(ROW_WIDTH - EDGE_MARGIN - int'(st_sel) + WINDOW_LEN);

  assign rd_inrow  = !rd_col[CW-1] && (rd_col < ROW_END_C);
  assign rd_addr   = rd_inrow ? rd_col[AW-1:0] : '0;
  assign issue     = (rd_cnt != '0);
  assign pix_in    = p_inrow ? rdata : '0;
  assign cand      = (state == S_LEFT) ? EDGE_W'(int'(p_col) + (WINDOW_LEN - 1))
                                       : EDGE_W'(int'(p_col) - (WINDOW_LEN - 1));
  assign mid_sum   = {1'b0, left_e} + {1'b0, right_e};

  lsc_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (win_ctrl),
    .pixel      (pix_in),
    .dark_limit (dark_limit),
    .hit        (hit)
  );

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[column_count] <= pixel;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    state_next        = state;
    column_count_next = column_count;
    mem_wr            = 1'b0;
    rd_col_next       = rd_col;
    rd_cnt_next       = rd_cnt;
    p_valid_next      = 1'b0;
    p_inrow_next      = p_inrow;
    p_col_next        = p_col;
    start_col_next    = start_col;
    left_e_next       = left_e;
    right_e_next      = right_e;
    done_next         = 1'b0;
    midpoint_next     = midpoint;
    left_edge_next    = left_edge;
    right_edge_next   = right_edge;
    win_ctrl          = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          mem_wr = 1'b1;
          column_count_next = (column_count == AW'(ROW_WIDTH - 1)) ? '0
                                                                   : column_count + AW'(1);
          if (row_end) begin
            column_count_next = '0;
            start_col_next    = st_clamp;
            left_e_next       = '0;
            right_e_next      = EDGE_W'(ROW_WIDTH);
            win_ctrl.clear    = 1'b1;
            rd_col_next       = CW'(st_clamp);
            if (left_ok) begin
              state_next  = S_LEFT;
              rd_cnt_next = left_cnt;
            end else if (right_ok) begin
              state_next  = S_RIGHT;
              rd_cnt_next = right_cnt;
            end else begin
              state_next  = S_EMIT;
            end
          end
        end
      end
      S_LEFT, S_RIGHT: begin
        if (issue) begin
          p_valid_next = 1'b1;
          p_inrow_next = rd_inrow;
          p_col_next   = rd_col;
          rd_col_next  = (state == S_LEFT) ? rd_col - ONE_C : rd_col + ONE_C;
          rd_cnt_next  = rd_cnt - CNT_W'(1);
        end
        win_ctrl.push = p_valid;
        if (p_valid && (hit || !issue)) begin
          if (hit) begin
            if (state == S_LEFT) begin
              left_e_next = cand;
            end else begin
              right_e_next = cand;
            end
          end
          p_valid_next = 1'b0;
          if ((state == S_LEFT) && right_ok) begin
            state_next     = S_RIGHT;
            win_ctrl.clear = 1'b1;
            rd_col_next    = CW'(start_col);
            rd_cnt_next    = right_cnt;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        midpoint_next   = OUT_W'(mid_sum[EDGE_W:1]);
        left_edge_next  = OUT_W'(left_e);
        right_edge_next = OUT_W'(right_e);
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      dark_limit   <= DARK_LIMIT_RESET;
      p_valid      <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      column_count <= column_count_next;
      p_valid      <= p_valid_next;
      done         <= done_next;
      if (cfg_valid && cfg_ready) begin
        dark_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_col     <= rd_col_next;
    rd_cnt     <= rd_cnt_next;
    p_inrow    <= p_inrow_next;
    p_col      <= p_col_next;
    start_col  <= start_col_next;
    left_e     <= left_e_next;
    right_e    <= right_e_next;
    midpoint   <= midpoint_next;
    left_edge  <= left_edge_next;
    right_edge <= right_edge_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lsc_checker.sv -----
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks of the lane-centre search: item handshake against the
// search phase and the one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic row_end,
  input logic done
);

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while search still running");

  a_pixel_no_search: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !row_end) |=> !busy)
    else $error("mid-row item started a search");

  a_row_end_search: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && row_end) |=> (busy && !done))
    else $error("row end item did not start a search");

endmodule

bind scanline_lane_center_search_core lsc_checker u_lsc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .row_end (row_end),
  .done    (done)
);

`default_nettype wire
